[rtl/core/shash_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shash_pkg
// Constants and round functions of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package shash_pkg;

    typedef logic [31:0] word_t;

    localparam int unsigned HASH_WORDS  = 8;
    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned ROUNDS      = 64;

    // first padding byte and where the length field starts
    localparam logic [7:0] PAD_FIRST_BYTE = 8'h80;
    localparam logic [5:0] LEN_START      = 6'd56;
    localparam logic [63:0] BYTE_BITS     = 64'd8;

    localparam word_t HASH_INIT [HASH_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t rotr(input word_t v, input int unsigned n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

    function automatic word_t big_sigma0(input word_t v);
        big_sigma0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
    endfunction

    function automatic word_t big_sigma1(input word_t v);
        big_sigma1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
    endfunction

    function automatic word_t small_sigma0(input word_t v);
        small_sigma0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
    endfunction

    function automatic word_t small_sigma1(input word_t v);
        small_sigma1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
    endfunction

endpackage

[rtl/core/sha256_stream_hasher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 over a byte stream, one compression round per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests carry one optional message byte (s_has_byte, s_data_byte)
//   and an end flag (s_is_last). s_ready is high only while the block is idle.
//   A byte without end flag that does not complete a 64-byte block keeps s_ready high.
//   A byte that completes a block runs the 64 rounds and then the hash update
//   before the next request is taken; the shared round datapath and the
//   16-word schedule shift line carry every round.
//   On an end request the sequencer inserts padding and length bytes one a
//   cycle: (64 - fill) bytes, or (128 - fill) when fewer than nine bytes are
//   free, plus the 64 rounds and the hash update of every block run. The eight
//   digest words then leave on the result channel, word 0 (most significant)
//   first, m_last_word on the eighth; a stalled receiver holds the word.
//   After the eighth word the initial hash, fill count and bit length are
//   reloaded and s_ready returns, so a new message can follow.
//   Reset (aresetn low, synchronous) returns to idle with the initial hash.
// ----------------------------------------------------------------------------
module sha256_stream_hasher
    import shash_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_has_byte,
    input  logic [7:0]  s_data_byte,
    input  logic        s_is_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_ADD   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bit_len_reg, bit_len_next;
    logic [5:0]  round_reg, round_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    logic        end_pend_reg, end_pend_next;   // end request seen, pad after block
    logic        pad_first_reg, pad_first_next; // next pad byte is the 0x80 marker
    logic        len_phase_reg, len_phase_next; // pad is inserting length bytes
    logic        final_reg, final_next;         // running block is the last one

    word_t hash_reg [HASH_WORDS];
    word_t hash_next [HASH_WORDS];
    word_t win_reg [BLOCK_WORDS];
    word_t win_next [BLOCK_WORDS];
    word_t wv_reg [HASH_WORDS];
    word_t wv_next [HASH_WORDS];

    logic        ins_en;
    logic [7:0]  ins_byte;
    logic [5:0]  fill_inc;
    logic [63:0] len_shifted;
    word_t       sched_new, t1, t2;
    logic        s_fire, m_fire;

    assign s_ready       = (state_reg == ST_IDLE);
    assign s_fire        = s_valid && s_ready;
    assign m_valid       = (state_reg == ST_OUT);
    assign m_fire        = m_valid && m_ready;
    assign m_digest_word = hash_reg[out_idx_reg];
    assign m_word_index  = out_idx_reg;
    assign m_last_word   = (out_idx_reg == 3'd7);

    assign fill_inc    = fill_reg + 6'd1;
    assign len_shifted = bit_len_reg >> {~fill_reg[2:0], 3'b000};

    // round datapath and next schedule word
    always_comb begin
        sched_new = small_sigma1(win_reg[14]) + win_reg[9]
                  + small_sigma0(win_reg[1]) + win_reg[0];
        t1 = wv_reg[7] + big_sigma1(wv_reg[4])
           + ((wv_reg[4] & wv_reg[5]) ^ (~wv_reg[4] & wv_reg[6]))
           + ROUND_K[round_reg] + win_reg[0];
        t2 = big_sigma0(wv_reg[0])
           + ((wv_reg[0] & wv_reg[1]) ^ (wv_reg[0] & wv_reg[2]) ^ (wv_reg[1] & wv_reg[2]));
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        bit_len_next   = bit_len_reg;
        round_next     = round_reg;
        out_idx_next   = out_idx_reg;
        end_pend_next  = end_pend_reg;
        pad_first_next = pad_first_reg;
        len_phase_next = len_phase_reg;
        final_next     = final_reg;
        hash_next      = hash_reg;
        wv_next        = wv_reg;
        ins_en         = 1'b0;
        ins_byte       = s_data_byte;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_has_byte) begin
                        ins_en       = 1'b1;
                        fill_next    = fill_inc;
                        bit_len_next = bit_len_reg + BYTE_BITS;
                    end
                    if (s_has_byte && fill_inc == 6'd0) begin
                        state_next     = ST_ROUND;
                        round_next     = 6'd0;
                        wv_next        = hash_reg;
                        end_pend_next  = s_is_last;
                        pad_first_next = s_is_last;
                        final_next     = 1'b0;
                    end else if (s_is_last) begin
                        state_next     = ST_PAD;
                        pad_first_next = 1'b1;
                        len_phase_next = 1'b0;
                    end
                end
            end
            ST_PAD: begin
                ins_en    = 1'b1;
                fill_next = fill_inc;
                if (pad_first_reg) begin
                    ins_byte = PAD_FIRST_BYTE;
                end else if (len_phase_reg) begin
                    ins_byte = len_shifted[7:0];
                end else begin
                    ins_byte = 8'h00;
                end
                pad_first_next = 1'b0;
                if (!len_phase_reg && fill_inc == LEN_START) begin
                    len_phase_next = 1'b1;
                end
                if (fill_inc == 6'd0) begin
                    state_next     = ST_ROUND;
                    round_next     = 6'd0;
                    wv_next        = hash_reg;
                    final_next     = len_phase_reg;
                    end_pend_next  = !len_phase_reg;
                    len_phase_next = 1'b0;
                end
            end
            ST_ROUND: begin
                wv_next[7] = wv_reg[6];
                wv_next[6] = wv_reg[5];
                wv_next[5] = wv_reg[4];
                wv_next[4] = wv_reg[3] + t1;
                wv_next[3] = wv_reg[2];
                wv_next[2] = wv_reg[1];
                wv_next[1] = wv_reg[0];
                wv_next[0] = t1 + t2;
                round_next = round_reg + 6'd1;
                if (round_reg == 6'd63) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                for (int j = 0; j < HASH_WORDS; j++) begin
                    hash_next[j] = hash_reg[j] + wv_reg[j];
                end
                if (final_reg) begin
                    state_next   = ST_OUT;
                    out_idx_next = 3'd0;
                end else if (end_pend_reg) begin
                    // padding still owed: the marker after a full last byte, or the length block
                    state_next     = ST_PAD;
                    len_phase_next = 1'b0;
                    end_pend_next  = 1'b0;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (m_fire) begin
                    out_idx_next = out_idx_reg + 3'd1;
                    if (out_idx_reg == 3'd7) begin
                        state_next    = ST_IDLE;
                        hash_next     = HASH_INIT;
                        fill_next     = 6'd0;
                        bit_len_next  = 64'd0;
                        final_next    = 1'b0;
                        end_pend_next = 1'b0;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // schedule window: byte shift line while filling, word shift while rounding
    always_comb begin
        win_next = win_reg;
        if (state_reg == ST_ROUND) begin
            for (int k = 0; k < BLOCK_WORDS - 1; k++) begin
                win_next[k] = win_reg[k + 1];
            end
            win_next[BLOCK_WORDS - 1] = sched_new;
        end else if (ins_en) begin
            for (int k = 0; k < BLOCK_WORDS - 1; k++) begin
                win_next[k] = {win_reg[k][23:0], win_reg[k + 1][31:24]};
            end
            win_next[BLOCK_WORDS - 1] = {win_reg[BLOCK_WORDS - 1][23:0], ins_byte};
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= 6'd0;
            bit_len_reg   <= 64'd0;
            round_reg     <= 6'd0;
            out_idx_reg   <= 3'd0;
            end_pend_reg  <= 1'b0;
            pad_first_reg <= 1'b0;
            len_phase_reg <= 1'b0;
            final_reg     <= 1'b0;
            hash_reg      <= HASH_INIT;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            bit_len_reg   <= bit_len_next;
            round_reg     <= round_next;
            out_idx_reg   <= out_idx_next;
            end_pend_reg  <= end_pend_next;
            pad_first_reg <= pad_first_next;
            len_phase_reg <= len_phase_next;
            final_reg     <= final_next;
            hash_reg      <= hash_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        win_reg <= win_next;
        wv_reg  <= wv_next;
    end

endmodule

[rtl/core/shash_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shash_checker
// Port-level checks of the SHA-256 stream hasher, bound to the top level.
// ----------------------------------------------------------------------------
module shash_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_digest_word,
    input logic [2:0]  m_word_index,
    input logic        m_last_word
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_digest_word) && $stable(m_word_index))
    else $error("stalled digest word changed");

    // no new request is taken while the digest is being delivered
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
    else $error("input ready during digest output");

    // digest words follow each other in order
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_word |=>
            m_valid && (m_word_index == $past(m_word_index) + 3'd1))
    else $error("digest word order broken");

    // last flag marks the eighth word only
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_word == (m_word_index == 3'd7)))
    else $error("last word flag mismatch");

endmodule

bind sha256_stream_hasher shash_checker u_shash_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_digest_word (m_digest_word),
    .m_word_index  (m_word_index),
    .m_last_word   (m_last_word)
);

[sim/digest_check_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// digest_check_pkg
// Digest predictor and result checker for the SHA-256 stream hasher bench.
// Keeps its own copy of the chaining value, block buffer and bit count. It
// works out the eight digest words of every finished message and checks the
// words the block sends back, in order, field by field.
// ----------------------------------------------------------------------------
package digest_check_pkg;

    import shash_pkg::word_t;

    // one digest word as it should leave the block
    typedef struct packed {
        word_t      word;
        logic [2:0] index;
        logic       last;
    } digest_item_t;

    localparam word_t IV_WORDS [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_CONST [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // rotate right through a doubled word
    function automatic word_t ror(input word_t x, input int n);
        logic [63:0] twice;
        twice = {x, x} >> n;
        return twice[31:0];
    endfunction

    function automatic word_t ep0(input word_t x);
        return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic word_t ep1(input word_t x);
        return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction

    function automatic word_t sg0(input word_t x);
        return ror(x, 7) ^ ror(x, 18) ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t sg1(input word_t x);
        return ror(x, 17) ^ ror(x, 19) ^ {10'd0, x[31:10]};
    endfunction

    class digest_checker;

        word_t        chain [8];
        logic [7:0]   blk [64];
        logic [5:0]   fill;
        logic [63:0]  bit_len;
        digest_item_t digest_queue [$];
        int unsigned  mismatches;
        int unsigned  words_checked;

        function new();
            mismatches    = 0;
            words_checked = 0;
            for (int i = 0; i < 64; i++) begin
                blk[i] = 8'h00;
            end
            restart();
        endfunction

        // fresh message: initial hash, empty buffer, zero length
        function void restart();
            for (int i = 0; i < 8; i++) begin
                chain[i] = IV_WORDS[i];
            end
            fill    = 6'd0;
            bit_len = 64'd0;
        endfunction

        // one 64-round compression of the buffered block into the chain
        function void compress();
            word_t sched [16];
            word_t v [8];
            word_t wt;
            word_t t1;
            word_t t2;
            for (int j = 0; j < 16; j++) begin
                sched[j] = {blk[4*j], blk[4*j+1], blk[4*j+2], blk[4*j+3]};
            end
            for (int j = 0; j < 8; j++) begin
                v[j] = chain[j];
            end
            for (int t = 0; t < 64; t++) begin
                if (t < 16) begin
                    wt = sched[t];
                end else begin
                    wt = sched[t & 15] + sg0(sched[(t - 15) & 15])
                         + sched[(t - 7) & 15] + sg1(sched[(t - 2) & 15]);
                    sched[t & 15] = wt;
                end
                t1 = v[7] + ep1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
                     + ROUND_CONST[t] + wt;
                t2 = ep0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6];
                v[6] = v[5];
                v[5] = v[4];
                v[4] = v[3] + t1;
                v[3] = v[2];
                v[2] = v[1];
                v[1] = v[0];
                v[0] = t1 + t2;
            end
            for (int j = 0; j < 8; j++) begin
                chain[j] = chain[j] + v[j];
            end
        endfunction

        // accepted request: absorb the byte, then pad and queue the digest on end
        function void take_request(input bit has, input logic [7:0] data, input bit last);
            int pos;
            digest_item_t item;
            if (has) begin
                blk[fill] = data;
                bit_len   = bit_len + 64'd8;
                fill      = fill + 6'd1;
                if (fill == 6'd0) begin
                    compress();
                end
            end
            if (!last) begin
                return;
            end
            pos      = fill;
            blk[pos] = 8'h80;
            pos++;
            // not enough room for the length: flush a zero-filled block first
            if (pos > 56) begin
                while (pos < 64) begin
                    blk[pos] = 8'h00;
                    pos++;
                end
                compress();
                pos = 0;
            end
            while (pos < 56) begin
                blk[pos] = 8'h00;
                pos++;
            end
            for (int j = 0; j < 8; j++) begin
                blk[56 + j] = bit_len[63 - 8*j -: 8];
            end
            compress();
            for (int j = 0; j < 8; j++) begin
                item.word  = chain[j];
                item.index = j[2:0];
                item.last  = (j == 7);
                digest_queue.push_back(item);
            end
            restart();
        endfunction

        function int unsigned pending();
            return digest_queue.size();
        endfunction

        function void report(input string what);
            $display("[%0t] mismatch: %s", $time, what);
            mismatches++;
        endfunction

        // accepted result word against the oldest expected one
        function void check_word(input word_t word, input logic [2:0] index, input logic last);
            digest_item_t want;
            words_checked++;
            if (digest_queue.size() == 0) begin
                report($sformatf("word %h index %0d with no digest pending", word, index));
                return;
            end
            want = digest_queue.pop_front();
            if (word !== want.word) begin
                report($sformatf("word %0d: digest %h, want %h",
                                 words_checked, word, want.word));
            end
            if (index !== want.index) begin
                report($sformatf("word %0d: index %0d, want %0d",
                                 words_checked, index, want.index));
            end
            if (last !== want.last) begin
                report($sformatf("word %0d: last flag %b, want %b",
                                 words_checked, last, want.last));
            end
        endfunction

    endclass

endpackage

[sim/tb_sha256_stream_hasher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sha256_stream_hasher
// Self-checking bench for the SHA-256 stream hasher.
// A few directed messages (empty, short, end with and without a byte, idle
// requests) are followed by random messages, short ones or with lengths around the padding
// and block boundaries. Both handshakes idle at random and the result side
// once holds off for a long stretch so the block backs up its input.
// ----------------------------------------------------------------------------
module tb_sha256_stream_hasher;

    import shash_pkg::*;
    import digest_check_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_has_byte = 1'b0;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_is_last = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_digest_word;
    logic [2:0]  m_word_index;
    logic        m_last_word;

    digest_checker sb;
    bit            sender_gaps;
    int unsigned   stim_items;
    int unsigned   boundary_lens [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

    sha256_stream_hasher dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_has_byte    (s_has_byte),
        .s_data_byte   (s_data_byte),
        .s_is_last     (s_is_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digest_word (m_digest_word),
        .m_word_index  (m_word_index),
        .m_last_word   (m_last_word)
    );

    // 10 ns clock
    always #5 aclk = ~aclk;

    // offer one request and wait for it to be taken
    task automatic send_request(input bit has, input logic [7:0] data, input bit last);
        int unsigned gap;
        gap = sender_gaps ? $urandom_range(0, 14) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_has_byte  <= has;
        s_data_byte <= data;
        s_is_last   <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.take_request(has, data, last);
        if (has || last) begin
            stim_items++;
        end
    endtask

    // one message of random bytes, with the odd idle request mixed in
    task automatic send_message(input int unsigned len, input bit end_on_byte);
        sender_gaps = ($urandom_range(0, 3) != 0);
        for (int unsigned i = 0; i < len; i++) begin
            if ($urandom_range(0, 11) == 0) begin
                send_request(1'b0, 8'($urandom), 1'b0);
            end
            send_request(1'b1, 8'($urandom), end_on_byte && (i == len - 1));
        end
        if (!end_on_byte) begin
            send_request(1'b0, 8'($urandom), 1'b1);
        end
    endtask

    // result side: random stalls per word, one long hold-off
    task automatic drain_results();
        int unsigned gap;
        bit          gaps_on;
        forever begin
            if (sb.words_checked % 8 == 0) begin
                gaps_on = ($urandom_range(0, 2) != 0);
            end
            if (sb.words_checked == 56) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
            end
            gap = gaps_on ? $urandom_range(0, 14) : 0;
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            sb.check_word(m_digest_word, m_word_index, m_last_word);
        end
    endtask

    // run limit
    initial begin
        #10000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // main sequence
    initial begin
        int unsigned len;
        sb          = new();
        stim_items  = 0;
        sender_gaps = 1'b0;
        fork
            drain_results();
        join_none

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: idle request, empty message
        send_request(1'b0, 8'hc3, 1'b0);
        send_request(1'b0, 8'h3c, 1'b1);
        // "abc", end on the last byte
        send_request(1'b1, 8'h61, 1'b0);
        send_request(1'b1, 8'h62, 1'b0);
        send_request(1'b1, 8'h63, 1'b1);
        // single all-ones byte with end
        sender_gaps = 1'b1;
        send_request(1'b1, 8'hff, 1'b1);
        // zero byte, then end without a byte
        send_request(1'b1, 8'h00, 1'b0);
        send_request(1'b0, 8'hff, 1'b1);
        // idle request in the middle of a message
        send_request(1'b1, 8'h5a, 1'b0);
        send_request(1'b0, 8'h81, 1'b0);
        send_request(1'b1, 8'ha5, 1'b1);
        // back-to-back empty messages
        sender_gaps = 1'b0;
        send_request(1'b0, 8'h00, 1'b1);
        send_request(1'b0, 8'h7e, 1'b1);

        // random messages, some sized at the padding and block boundaries
        while (stim_items < 350) begin
            if ($urandom_range(0, 9) < 7) begin
                len = $urandom_range(0, 20);
            end else begin
                len = boundary_lens[$urandom_range(0, 9)];
            end
            send_message(len, (len != 0) && ($urandom_range(0, 1) != 0));
        end
        s_valid <= 1'b0;

        // drain and let the block settle
        while (sb.pending() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);

        if (sb.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/shash_pkg.sv
rtl/core/sha256_stream_hasher.sv
rtl/core/shash_checker.sv
sim/digest_check_pkg.sv
sim/tb_sha256_stream_hasher.sv
